// ===== hdl/pva_pkg.sv =====
// Package for the polar vector adder: types, constants and the arctangent table.
`default_nettype none
package pva_pkg;

    localparam int PVA_ROTATION_STEPS = 16;
    localparam int PVA_RADIUS_BITS    = 32;
    localparam int PVA_GUARD_BITS     = 16;
    localparam int PVA_COORD_W        = 64;
    localparam int PVA_ANGLE_W        = 32;

    localparam logic [31:0] PVA_INV_GAIN_SQ = 32'd1583795506;
    localparam logic [31:0] PVA_HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0] PVA_QUARTER     = 32'h4000_0000;

    typedef struct packed {
        logic signed [PVA_COORD_W-1:0] x;
        logic signed [PVA_COORD_W-1:0] y;
        logic        [PVA_ANGLE_W-1:0] z;
    } pva_vec_t;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [31:0] pva_atan(input int unsigned i);
        logic [31:0] a;
        unique case (i)
            0:  a = 32'h20000000;  1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;  3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;  9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;  11: a = 32'h000517CC;
            12: a = 32'h00028BE6;  13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;  15: a = 32'h0000517D;
            16: a = 32'h000028BE;  17: a = 32'h0000145F;
            18: a = 32'h00000A30;  19: a = 32'h00000518;
            20: a = 32'h0000028C;  21: a = 32'h00000146;
            22: a = 32'h000000A3;  23: a = 32'h00000051;
            24: a = 32'h00000029;  25: a = 32'h00000014;
            26: a = 32'h0000000A;  27: a = 32'h00000005;
            28: a = 32'h00000003;  29: a = 32'h00000001;
            30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pva_if.sv =====
// Valid/ready stream interfaces for the operand and result words.
`default_nettype none
interface pva_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] radius_a;
    logic [15:0] angle_a;
    logic [31:0] radius_b;
    logic [15:0] angle_b;
    modport source (output valid, radius_a, angle_a, radius_b, angle_b, input ready);
    modport sink   (input valid, radius_a, angle_a, radius_b, angle_b, output ready);
endinterface

interface pva_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] radius_sum;
    logic [15:0] angle_sum;
    logic        overflow;
    modport source (output valid, radius_sum, angle_sum, overflow, input ready);
    modport sink   (input valid, radius_sum, angle_sum, overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/pva_cordic_step.sv =====
// One registered CORDIC micro-rotation, rotation or vectoring mode.
`default_nettype none
module pva_cordic_step #(
    parameter int STEP      = 0,
    parameter bit VECTORING = 1'b0
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire pva_pkg::pva_vec_t d,
    output pva_pkg::pva_vec_t      q
);
    import pva_pkg::*;

    localparam logic [31:0] ATAN = pva_atan(STEP);

    pva_vec_t q_reg;
    pva_vec_t q_next;
    logic     sub_dir;

    always_comb
    begin
        // vectoring drives y to zero, rotation drives z to zero
        sub_dir = VECTORING ? d.y[PVA_COORD_W-1] : d.z[PVA_ANGLE_W-1];
        if (VECTORING ? !sub_dir : !sub_dir)
        begin
            if (VECTORING)
            begin
                q_next.x = d.x + (d.y >>> STEP);
                q_next.y = d.y - (d.x >>> STEP);
                q_next.z = d.z + ATAN;
            end
            else
            begin
                q_next.x = d.x - (d.y >>> STEP);
                q_next.y = d.y + (d.x >>> STEP);
                q_next.z = d.z - ATAN;
            end
        end
        else
        begin
            if (VECTORING)
            begin
                q_next.x = d.x - (d.y >>> STEP);
                q_next.y = d.y + (d.x >>> STEP);
                q_next.z = d.z - ATAN;
            end
            else
            begin
                q_next.x = d.x + (d.y >>> STEP);
                q_next.y = d.y - (d.x >>> STEP);
                q_next.z = d.z + ATAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

// ===== hdl/polar_vector_adder.sv =====
// Top level of the polar vector adder: CORDIC rotate, add, CORDIC vectoring, gain fix.
// Pipeline: input fold, rotation steps, add, fold, vectoring steps, partial products, sum, round.
// Throughput: one word per cycle while not stalled; each stage is one CORDIC step, one add or fold,
// two 32x32 multiplies, or one round and saturate.
// Stall: the whole pipeline holds while the result register is full and not taken.
// Reset: rst_n clears all stage valid bits; payload registers are not reset.
`default_nettype none
module polar_vector_adder #(
    parameter int ROTATION_STEPS = pva_pkg::PVA_ROTATION_STEPS,
    parameter int RADIUS_BITS    = pva_pkg::PVA_RADIUS_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pva_in_if.sink    operands,
    pva_out_if.source result
);
    import pva_pkg::*;

    // rotation steps and radius bits are capped at 32
    localparam int N      = (ROTATION_STEPS < 32) ? ROTATION_STEPS : 32;
    localparam int RB     = (RADIUS_BITS < 32) ? RADIUS_BITS : 32;
    localparam int DEPTH  = 2 * N + 6;
    localparam int MAG_W  = 48;
    localparam logic [MAG_W-1:0] MAX_RADIUS = (MAG_W'(1) << RB) - MAG_W'(1);

    // index of the result register in the valid chain
    localparam int S_OUT  = 2 * N + 5;

    logic [DEPTH-1:0] valid_reg;
    logic             advance;

    // advance everything unless the result word is held by the sink
    assign advance        = !valid_reg[S_OUT] || result.ready;
    assign operands.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], operands.valid};
        end
    end

    // ---------------------------------------------------------------
    // Input stage: lift radius into guard format, fold angle into
    // the right half plane by a half turn when it points left.
    // ---------------------------------------------------------------
    pva_vec_t in_a_reg, in_b_reg;

    function automatic pva_vec_t pre_rotate(input logic [31:0] radius, input logic [15:0] angle);
        pva_vec_t v;
        logic [31:0] zq;
        v.x = {16'd0, radius, 16'd0};
        v.y = '0;
        v.z = {angle, 16'd0};
        zq  = v.z + PVA_QUARTER;
        if (zq[31])
        begin
            v.x = -v.x;
            v.z = v.z - PVA_HALF_TURN;
        end
        return v;
    endfunction

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_a_reg <= pre_rotate(operands.radius_a, operands.angle_a);
            in_b_reg <= pre_rotate(operands.radius_b, operands.angle_b);
        end
    end

    // rotation chain, both vectors side by side
    pva_vec_t rot_a [N+1];
    pva_vec_t rot_b [N+1];
    assign rot_a[0] = in_a_reg;
    assign rot_b[0] = in_b_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        pva_cordic_step #(.STEP(i), .VECTORING(1'b0)) u_step_a (
            .clk(clk), .en(advance), .d(rot_a[i]), .q(rot_a[i+1])
        );
        pva_cordic_step #(.STEP(i), .VECTORING(1'b0)) u_step_b (
            .clk(clk), .en(advance), .d(rot_b[i]), .q(rot_b[i+1])
        );
    end

    // add the rectangular vectors
    logic signed [PVA_COORD_W-1:0] sum_x_reg, sum_y_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_x_reg <= rot_a[N].x + rot_b[N].x;
            sum_y_reg <= rot_a[N].y + rot_b[N].y;
        end
    end

    // fold into the right half plane before vectoring
    pva_vec_t vec_s [N+1];
    pva_vec_t pre_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (sum_x_reg[PVA_COORD_W-1])
            begin
                pre_reg.x <= -sum_x_reg;
                pre_reg.y <= -sum_y_reg;
                pre_reg.z <= PVA_HALF_TURN;
            end
            else
            begin
                pre_reg.x <= sum_x_reg;
                pre_reg.y <= sum_y_reg;
                pre_reg.z <= '0;
            end
        end
    end
    assign vec_s[0] = pre_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        pva_cordic_step #(.STEP(i), .VECTORING(1'b1)) u_step (
            .clk(clk), .en(advance), .d(vec_s[i]), .q(vec_s[i+1])
        );
    end

    // gain removal: two 32x32 partial products against 1/K^2
    logic [PVA_COORD_W-1:0] mag_x;
    logic [63:0]            prod_hi_reg, prod_lo_reg;
    logic [31:0]            z_mul_reg, z_sum_reg;
    assign mag_x = vec_s[N].x[PVA_COORD_W-1] ? '0 : vec_s[N].x;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_hi_reg <= mag_x[63:32] * PVA_INV_GAIN_SQ;
            prod_lo_reg <= mag_x[31:0] * PVA_INV_GAIN_SQ;
            z_mul_reg   <= vec_s[N].z;
        end
    end

    logic [63:0] scaled_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scaled_reg <= prod_hi_reg + {32'd0, prod_lo_reg[63:32]};
            z_sum_reg  <= z_mul_reg;
        end
    end

    // round to Q16.16, saturate, round the angle
    logic [63:0]      rounded;
    logic [MAG_W-1:0] mag;
    logic             sat;
    logic [31:0]      z_round;
    logic [31:0]      radius_reg;
    logic [15:0]      angle_reg;
    logic             ovf_reg;

    assign rounded = scaled_reg + 64'h8000;
    assign mag     = rounded[MAG_W+15:16];
    assign sat     = mag > MAX_RADIUS;
    assign z_round = z_sum_reg + 32'h8000;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            radius_reg <= sat ? MAX_RADIUS[31:0] : mag[31:0];
            // zero length has no direction
            angle_reg  <= (mag == '0) ? 16'd0 : z_round[31:16];
            ovf_reg    <= sat;
        end
    end

    assign result.valid      = valid_reg[S_OUT];
    assign result.radius_sum = radius_reg;
    assign result.angle_sum  = angle_reg;
    assign result.overflow   = ovf_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_ovf_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.overflow |-> result.radius_sum == MAX_RADIUS[31:0])
        else $error("overflow without saturated radius");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.radius_sum == 32'd0 |-> result.angle_sum == 16'd0)
        else $error("nonzero angle on zero radius");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        operands.valid && operands.ready |=> valid_reg[0])
        else $error("accepted word did not enter the pipeline");
endmodule
`default_nettype wire

// ===== test/polar_vector_adder_tb.sv =====
// Self-checking testbench for the polar vector adder: directed, random and stall tests.
`timescale 1ns / 100ps
module polar_vector_adder_tb;
    import pva_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LATENCY      = 2 * PVA_ROTATION_STEPS + 6;
    localparam int RANDOM_ITEMS = 826;

    // Expected result word for one operand word.
    typedef struct packed {
        logic [31:0] radius_sum;
        logic [15:0] angle_sum;
        logic        overflow;
    } polar_sum_t;

    // Arctangent of 2^-i, 2^32 per turn.
    localparam logic [31:0] ARCTAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    logic clk;
    logic rst_n;

    pva_in_if  operands_if ();
    pva_out_if result_if ();

    polar_vector_adder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_if),
        .result   (result_if)
    );

    polar_sum_t pending_sums[$];
    int         error_count   = 0;
    int         words_sent    = 0;
    int         words_checked = 0;
    int         overflow_seen = 0;
    int         hold_cycles   = 0;
    int         cycle_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Polar to rectangular with CORDIC rotation; the result carries gain K.
    function automatic void cordic_rotate(input logic [31:0] radius, input logic [15:0] angle,
                                          output longint xo, output longint yo);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        logic [31:0] shifted;
        x = longint'({32'd0, radius}) << PVA_GUARD_BITS;
        y = 0;
        z = {angle, 16'h0000};
        shifted = z + PVA_QUARTER;
        // Angles in the left half plane: pre-turn by a half turn.
        if (shifted >= PVA_HALF_TURN)
        begin
            x = -x;
            z = z - PVA_HALF_TURN;
        end
        for (int i = 0; i < PVA_ROTATION_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z[31] == 1'b0)
            begin
                x = x - dx; y = y + dy; z = z - ARCTAN_STEP[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + ARCTAN_STEP[i];
            end
        end
        xo = x;
        yo = y;
    endfunction

    // Full prediction: rotate both, add, vector back, remove both gains, saturate.
    function automatic polar_sum_t predict_sum(input logic [31:0] ra, input logic [15:0] aa,
                                               input logic [31:0] rb, input logic [15:0] ab);
        longint      xa, ya, xb, yb, x, y, dx, dy;
        logic [31:0] z;
        logic [31:0] zr;
        logic [63:0] xu, xl, xh, prod, mag;
        polar_sum_t  res;
        cordic_rotate(ra, aa, xa, ya);
        cordic_rotate(rb, ab, xb, yb);
        x = xa + xb;
        y = ya + yb;
        z = 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = PVA_HALF_TURN;
        end
        for (int i = 0; i < PVA_ROTATION_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + ARCTAN_STEP[i];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - ARCTAN_STEP[i];
            end
        end
        if (x < 0)
            x = 0;
        xu   = x;
        xl   = {32'd0, xu[31:0]};
        xh   = {32'd0, xu[63:32]};
        prod = xh * {32'd0, PVA_INV_GAIN_SQ} + ((xl * {32'd0, PVA_INV_GAIN_SQ}) >> 32);
        mag  = (prod + 64'h8000) >> 16;
        res.overflow = 1'b0;
        if (mag > 64'hFFFF_FFFF)
        begin
            mag = 64'hFFFF_FFFF;
            res.overflow = 1'b1;
        end
        zr = z + 32'h8000;
        res.radius_sum = mag[31:0];
        res.angle_sum  = (mag == 0) ? 16'd0 : zr[31:16];
        if (mag == 0)
            res.overflow = 1'b0;
        return res;
    endfunction

    // Offer one operand word at the falling edge and hold it until it is taken.
    // Valid stays high afterwards; idle_sender drops it.
    task automatic send_pair(input logic [31:0] ra, input logic [15:0] aa,
                             input logic [31:0] rb, input logic [15:0] ab);
        @(negedge clk);
        operands_if.valid    <= 1'b1;
        operands_if.radius_a <= ra;
        operands_if.angle_a  <= aa;
        operands_if.radius_b <= rb;
        operands_if.angle_b  <= ab;
        @(posedge clk);
        while (!operands_if.ready)
            @(posedge clk);
        pending_sums.push_back(predict_sum(ra, aa, rb, ab));
        words_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            operands_if.valid <= 1'b0;
        end
    endtask

    task automatic wait_for_drain();
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_radius();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 255);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2:       return $urandom & 32'h0003_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Extremes of both fields, every quadrant boundary, overflow and zero length.
    task automatic test_directed();
        send_pair(32'd0, 16'd0, 32'd0, 16'd0);
        send_pair(32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF, 16'h0000);
        send_pair(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_pair(32'hFFFF_FFFF, 16'h4000, 32'hFFFF_FFFF, 16'h4000);
        send_pair(32'h0001_0000, 16'h0000, 32'h0001_0000, 16'h8000);
        send_pair(32'h1234_5678, 16'h2000, 32'h1234_5678, 16'hA000);
        send_pair(32'h0000_0001, 16'h0000, 32'h0000_0000, 16'h0000);
        send_pair(32'h0001_0000, 16'h3FFF, 32'h0000_0000, 16'h0000);
        send_pair(32'h0001_0000, 16'h4000, 32'h0000_0000, 16'h0000);
        send_pair(32'h0001_0000, 16'hBFFF, 32'h0000_0000, 16'h0000);
        send_pair(32'h0001_0000, 16'hC000, 32'h0000_0000, 16'h0000);
        send_pair(32'h0001_0000, 16'h8000, 32'h0002_0000, 16'h8000);
        send_pair(32'h0003_0000, 16'h0000, 32'h0004_0000, 16'h4000);
        send_pair(32'h0003_0000, 16'h8000, 32'h0004_0000, 16'hC000);
        send_pair(32'h8000_0000, 16'h0000, 32'h8000_0000, 16'h0000);
        send_pair(32'h8000_0000, 16'h1000, 32'h7FFF_FFFF, 16'hF000);
        send_pair(32'hFFFF_FFFF, 16'h5555, 32'h0000_0000, 16'hAAAA);
        send_pair(32'hAAAA_AAAA, 16'hAAAA, 32'h5555_5555, 16'h5555);
        idle_sender(1);
        wait_for_drain();
    endtask

    // Random pairs in bursts of random length with random gaps between bursts.
    task automatic test_random(input int count);
        int burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 6));
            end
            burst_left--;
            send_pair(random_radius(), 16'($urandom), random_radius(), 16'($urandom));
        end
        idle_sender(1);
    endtask

    // Hold off the result side while words keep coming, so the pipeline fills.
    task automatic test_backpressure();
        hold_cycles = 3 * LATENCY;
        for (int n = 0; n < 2 * LATENCY; n++)
            send_pair(random_radius(), 16'($urandom), random_radius(), 16'($urandom));
        idle_sender(1);
        wait_for_drain();
    endtask

    // Pause the sender until every result is in, then resume.
    task automatic test_pause_and_resume();
        test_random(20);
        wait_for_drain();
        test_random(10);
        wait_for_drain();
    endtask

    // Result-side ready: four modes taken in turn as cycle_count advances; long hold-off overrides.
    always @(negedge clk)
    begin
        int mode;
        mode = (cycle_count / 64) % 4;
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            result_if.ready <= 1'b0;
        end
        else if (mode == 0)
            result_if.ready <= 1'b1;
        else if (mode == 1)
            result_if.ready <= ($urandom_range(0, 1) == 1);
        else if (mode == 2)
            result_if.ready <= (cycle_count % 5 != 0);
        else
            result_if.ready <= ($urandom_range(0, 7) == 0);
    end

    // Compare every taken result word against the oldest prediction.
    always @(posedge clk)
    begin
        polar_sum_t want;
        cycle_count++;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("result word with nothing pending");
                error_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                words_checked++;
                if (want.overflow)
                    overflow_seen++;
                if (result_if.radius_sum !== want.radius_sum)
                begin
                    $error("radius_sum expected %h got %h", want.radius_sum,
                           result_if.radius_sum);
                    error_count++;
                end
                if (result_if.angle_sum !== want.angle_sum)
                begin
                    $error("angle_sum expected %h got %h", want.angle_sum,
                           result_if.angle_sum);
                    error_count++;
                end
                if (result_if.overflow !== want.overflow)
                begin
                    $error("overflow expected %b got %b", want.overflow,
                           result_if.overflow);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pending", cycle_count,
                     pending_sums.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        operands_if.valid    = 1'b0;
        operands_if.radius_a = '0;
        operands_if.angle_a  = '0;
        operands_if.radius_b = '0;
        operands_if.angle_b  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_pause_and_resume();
        test_random(RANDOM_ITEMS);

        wait_for_drain();
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d operand words, checked %0d results (%0d saturated)",
                 words_sent, words_checked, overflow_seen);
        $display("covered quadrant edges, zero length, overflow, bursts and long stalls");
        if (error_count == 0 && pending_sums.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== polar_vector_adder.f =====
hdl/pva_pkg.sv
hdl/pva_if.sv
hdl/pva_cordic_step.sv
hdl/polar_vector_adder.sv
test/polar_vector_adder_tb.sv
